[hdl/q2e_pkg.sv]
// Package for the quaternion to Euler angle converter.
// Holds the CORDIC arctangent table and shared widths; no dependencies.
package q2e_pkg;

    localparam int AngTableLen = 24;
    localparam int PW = 40;              // product/vector width (values up to ~2^33 grown)
    localparam int AW = 34;              // angle accumulator width, 2^-30 rad
    localparam logic signed [AW-1:0] HalfPiQ30 = 34'sd1686629713;
    localparam logic signed [PW-1:0] OneQ28 = 40'sd268435456;

    function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [AW-1:0] v;
        begin
            unique case (idx)
                5'd0: v = 34'sd843314856;
                5'd1: v = 34'sd497837829;
                5'd2: v = 34'sd263043836;
                5'd3: v = 34'sd133525158;
                5'd4: v = 34'sd67021686;
                5'd5: v = 34'sd33543515;
                5'd6: v = 34'sd16775850;
                5'd7: v = 34'sd8388437;
                5'd8: v = 34'sd4194282;
                5'd9: v = 34'sd2097149;
                5'd10: v = 34'sd1048575;
                5'd11: v = 34'sd524287;
                5'd12: v = 34'sd262143;
                5'd13: v = 34'sd131071;
                5'd14: v = 34'sd65535;
                5'd15: v = 34'sd32767;
                5'd16: v = 34'sd16383;
                5'd17: v = 34'sd8191;
                5'd18: v = 34'sd4095;
                5'd19: v = 34'sd2047;
                5'd20: v = 34'sd1023;
                5'd21: v = 34'sd511;
                5'd22: v = 34'sd255;
                5'd23: v = 34'sd127;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[hdl/quaternion_to_euler.sv]
// Top level of the quaternion to Euler angle converter (ZYX convention).
// Depends on q2e_pkg for the arctangent table and widths.
//
// One request is accepted per cycle while the output is not stalled. Each request passes
// through 2 + 29 + 1 + CORDIC_STEPS + 1 register stages: products, a 29-step pipelined square
// root for the pitch cosine, an alignment stage, one stage per CORDIC iteration and a rounding
// stage. The pipeline only advances when the output register is free or being read, so a
// stall at the output holds every stage in place.
module quaternion_to_euler #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31], zero pad [47]
    output logic [47:0] m_axis_tdata
);
    import q2e_pkg::*;

    localparam int SQS = 29;                  // root bits of a 57-bit radicand
    localparam int RW = 58;                   // radicand width
    localparam int NST = 2 + SQS + 1 + CORDIC_STEPS + 1;

    logic adv;
    logic [NST-1:0] r_vld;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = r_vld[NST-1];

    // Stage 1: the nine products.
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_axis_tdata[15:0];
    assign qx = s_axis_tdata[31:16];
    assign qy = s_axis_tdata[47:32];
    assign qz = s_axis_tdata[63:48];
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wx <= qw * qx; r_yz <= qy * qz; r_xx <= qx * qx;
            r_yy <= qy * qy; r_wy <= qw * qy; r_zx <= qz * qx;
            r_wz <= qw * qz; r_xy <= qx * qy; r_zz <= qz * qz;
        end
    end

    // Stage 2: vector components and the clamped pitch sine.
    logic signed [PW-1:0] r_ry, r_rx, r_yy2, r_yx, r_s;
    logic signed [PW-1:0] n_s;
    always_comb begin
        n_s = 40'(r_wy) - 40'(r_zx);
        n_s = n_s <<< 1;
        if (n_s > OneQ28) n_s = OneQ28;
        if (n_s < -OneQ28) n_s = -OneQ28;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ry  <= (40'(r_wx) + 40'(r_yz)) <<< 1;
            r_rx  <= OneQ28 - ((40'(r_xx) + 40'(r_yy)) <<< 1);
            r_yy2 <= (40'(r_wz) + 40'(r_xy)) <<< 1;
            r_yx  <= OneQ28 - ((40'(r_yy) + 40'(r_zz)) <<< 1);
            r_s   <= n_s;
        end
    end

    // Square root pipeline: one root bit per stage, restoring method.
    logic signed [PW-1:0] sq_ry [SQS+1], sq_rx [SQS+1], sq_yy [SQS+1], sq_yx [SQS+1];
    logic signed [PW-1:0] sq_s [SQS+1];
    logic [RW-1:0] sq_rem [SQS+1];
    logic [SQS-1:0] sq_res [SQS+1];
    logic [28:0] s_abs;
    assign s_abs = 29'(r_s[PW-1] ? -r_s : r_s);
    assign sq_ry[0] = r_ry; assign sq_rx[0] = r_rx;
    assign sq_yy[0] = r_yy2; assign sq_yx[0] = r_yx; assign sq_s[0] = r_s;
    assign sq_rem[0] = (58'd1 << 56) - RW'(s_abs) * RW'(s_abs);
    assign sq_res[0] = '0;

    for (genvar k = 0; k < SQS; k++) begin : g_sqrt
        localparam int B = SQS - 1 - k;
        logic [RW+1:0] trial;
        logic [RW+1:0] rem_hi;
        logic [RW-1:0] n_rem;
        logic [SQS-1:0] n_res;
        always_comb begin
            trial = ({31'd0, sq_res[k]} << (B + 1)) + (60'd1 << (2 * B));
            rem_hi = {2'b00, sq_rem[k]};
            if (rem_hi >= trial) begin
                n_rem = RW'(rem_hi - trial);
                n_res = sq_res[k] | (SQS'(1) << B);
            end else begin
                n_rem = sq_rem[k];
                n_res = sq_res[k];
            end
        end
        logic signed [PW-1:0] r_a, r_b, r_c, r_d, r_e;
        logic [RW-1:0] r_rem;
        logic [SQS-1:0] r_res;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_a <= sq_ry[k]; r_b <= sq_rx[k]; r_c <= sq_yy[k];
                r_d <= sq_yx[k]; r_e <= sq_s[k];
                r_rem <= n_rem; r_res <= n_res;
            end
        end
        assign sq_ry[k+1] = r_a; assign sq_rx[k+1] = r_b;
        assign sq_yy[k+1] = r_c; assign sq_yx[k+1] = r_d; assign sq_s[k+1] = r_e;
        assign sq_rem[k+1] = r_rem; assign sq_res[k+1] = r_res;
    end

    // Alignment into the right half plane, three lanes.
    logic signed [PW-1:0] ly [3], lx [3];
    assign ly[0] = sq_ry[SQS];  assign lx[0] = sq_rx[SQS];
    assign ly[1] = sq_s[SQS];   assign lx[1] = PW'(sq_res[SQS]);
    assign ly[2] = sq_yy[SQS];  assign lx[2] = sq_yx[SQS];

    logic signed [PW-1:0] cx [3][CORDIC_STEPS+1], cy [3][CORDIC_STEPS+1];
    logic signed [AW-1:0] cz [3][CORDIC_STEPS+1];
    logic cnull [3][CORDIC_STEPS+1];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic signed [PW-1:0] r_x0, r_y0;
        logic signed [AW-1:0] r_z0;
        logic r_n0;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_n0 <= (lx[l] == '0) && (ly[l] == '0);
                if (lx[l] < 0 && ly[l] >= 0) begin
                    r_x0 <= ly[l]; r_y0 <= -lx[l]; r_z0 <= HalfPiQ30;
                end else if (lx[l] < 0) begin
                    r_x0 <= -ly[l]; r_y0 <= lx[l]; r_z0 <= -HalfPiQ30;
                end else begin
                    r_x0 <= lx[l]; r_y0 <= ly[l]; r_z0 <= '0;
                end
            end
        end
        assign cx[l][0] = r_x0; assign cy[l][0] = r_y0;
        assign cz[l][0] = r_z0; assign cnull[l][0] = r_n0;

        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
            logic signed [PW-1:0] r_x, r_y;
            logic signed [AW-1:0] r_z;
            logic r_n;
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_n <= cnull[l][i];
                    if (cy[l][i] >= 0) begin
                        r_x <= cx[l][i] + (cy[l][i] >>> i);
                        r_y <= cy[l][i] - (cx[l][i] >>> i);
                        r_z <= cz[l][i] + atan_q30(5'(i));
                    end else begin
                        r_x <= cx[l][i] - (cy[l][i] >>> i);
                        r_y <= cy[l][i] + (cx[l][i] >>> i);
                        r_z <= cz[l][i] - atan_q30(5'(i));
                    end
                end
            end
            assign cx[l][i+1] = r_x; assign cy[l][i+1] = r_y;
            assign cz[l][i+1] = r_z; assign cnull[l][i+1] = r_n;
        end
    end

    // Rounding and saturation.
    logic signed [AW-1:0] rnd [3];
    logic signed [16:0] ang [3];
    for (genvar l = 0; l < 3; l++) begin : g_rnd
        assign rnd[l] = (cz[l][CORDIC_STEPS] + 34'sd65536) >>> 17;
        always_comb begin
            logic signed [16:0] lim;
            lim = (l == 1) ? 17'sd12868 : 17'sd25736;
            if (cnull[l][CORDIC_STEPS]) ang[l] = '0;
            else if (rnd[l] > AW'(lim)) ang[l] = lim;
            else if (rnd[l] < -AW'(lim)) ang[l] = -lim;
            else ang[l] = 17'(rnd[l]);
        end
    end

    logic [47:0] r_out;
    always_ff @(posedge i_clk) begin
        if (adv) r_out <= {1'b0, ang[2][15:0], ang[1][14:0], ang[0][15:0]};
    end
    assign m_axis_tdata = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= 15'sd12868 &&
                           $signed(m_axis_tdata[30:16]) >= -15'sd12868))
        else $error("pitch out of range");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output empty");
endmodule

[dv/tb_quaternion_to_euler.sv]
// Self-checking testbench for quaternion_to_euler: random quaternions in, Euler angles out.
// Compares every result against a bit-exact CORDIC predictor written here in SystemVerilog.
// Depends only on the quaternion_to_euler RTL (and its package through the RTL).
module tb_quaternion_to_euler;

    localparam int Steps = 16;
    localparam int Latency = 2 + 29 + 1 + Steps + 1;
    localparam int WatchdogLimit = 20000;
    localparam longint HalfPi = 64'sd1686629713;
    localparam longint OutPi = 64'sd25736;
    localparam longint OutHalfPi = 64'sd12868;
    localparam longint One = 64'sd268435456;

    typedef struct packed {
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_w;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [14:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } t_euler;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    t_quat  pending_quats[$];
    t_euler expected_angles[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    int     hold_off = 0;
    int     hold_trigger = 300;
    int     received = 0;
    bit     stim_done = 1'b0;

    quaternion_to_euler #(.CORDIC_STEPS(Steps)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint atan_step(input int idx);
        longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                            16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                            131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
        return tbl[idx];
    endfunction

    function automatic longint floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(input longint yy, input longint xx,
                                            input longint lim);
        longint ang;
        longint t;
        longint dx;
        longint dy;
        longint r;
        ang = 0;
        if (xx == 0 && yy == 0) return 0;
        if (xx < 0) begin
            if (yy >= 0) begin
                t = xx; xx = yy; yy = -t; ang = HalfPi;
            end else begin
                t = xx; xx = -yy; yy = t; ang = -HalfPi;
            end
        end
        for (int i = 0; i < Steps && i < 24; i++) begin
            dx = yy >>> i;
            dy = xx >>> i;
            if (yy >= 0) begin
                xx += dx; yy -= dy; ang += atan_step(i);
            end else begin
                xx -= dx; yy += dy; ang -= atan_step(i);
            end
        end
        r = (ang + 65536) >>> 17;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_euler predict_angles(input t_quat q);
        longint w;
        longint x;
        longint y;
        longint z;
        longint s;
        longint c;
        longint r;
        t_euler e;
        w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
        r = vector_angle(2 * (w * x + y * z), One - 2 * (x * x + y * y), OutPi);
        e.roll_angle = r[15:0];
        s = 2 * (w * y - z * x);
        if (s > One) s = One;
        if (s < -One) s = -One;
        c = floor_sqrt(64'(One * One) - 64'(s * s));
        r = vector_angle(s, c, OutHalfPi);
        e.pitch_angle = r[14:0];
        r = vector_angle(2 * (w * z + x * y), One - 2 * (y * y + z * z), OutPi);
        e.yaw_angle = r[15:0];
        return e;
    endfunction

    function automatic t_quat random_unit_quat();
        real a;
        real b;
        real c;
        real d;
        real n;
        t_quat q;
        a = real'($urandom_range(2000)) - 1000.0;
        b = real'($urandom_range(2000)) - 1000.0;
        c = real'($urandom_range(2000)) - 1000.0;
        d = real'($urandom_range(2000)) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) begin
            a = 1.0; n = 1.0;
        end
        q.quat_w = 16'(int'($rtoi(16384.0 * a / n)));
        q.quat_x = 16'(int'($rtoi(16384.0 * b / n)));
        q.quat_y = 16'(int'($rtoi(16384.0 * c / n)));
        q.quat_z = 16'(int'($rtoi(16384.0 * d / n)));
        return q;
    endfunction

    function automatic t_quat make_quat(input int w, input int x, input int y, input int z);
        t_quat q;
        q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
        return q;
    endfunction

    initial begin
        t_quat q;
        int sel;
        // Identity, axis rotations, gimbal lock, zero vector, negative axis, extremes.
        pending_quats.push_back(make_quat(16384, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 16384, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 16384, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 16384));
        pending_quats.push_back(make_quat(11585, 0, 11585, 0));
        pending_quats.push_back(make_quat(11585, 0, -11585, 0));
        pending_quats.push_back(make_quat(11585, 11585, 0, 0));
        pending_quats.push_back(make_quat(11585, 0, 0, -11585));
        pending_quats.push_back(make_quat(-16384, 0, 0, 0));
        pending_quats.push_back(make_quat(-16384, -16384, -16384, -16384));
        pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
        pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
        pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
        pending_quats.push_back(make_quat(-32768, 32767, -32768, 32767));
        pending_quats.push_back(make_quat(32767, -32768, 32767, -32768));
        pending_quats.push_back(make_quat(8192, 8192, 8192, 8192));
        pending_quats.push_back(make_quat(8192, -8192, 8192, 8192));
        pending_quats.push_back(make_quat(1, 0, 0, 0));
        pending_quats.push_back(make_quat(0, -1, -1, 0));
        for (int i = 0; i < 1330; i++) begin
            sel = $urandom_range(9);
            if (sel < 6) begin
                q = random_unit_quat();
            end else if (sel < 8) begin
                q = make_quat($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                              $urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
            end else if (sel == 8) begin
                q = t_quat'({$urandom, $urandom});
            end else begin
                // Near gimbal lock: pitch argument close to or beyond one.
                q = make_quat(11585 + $urandom_range(40) - 20, $urandom_range(40) - 20,
                              11585 + $urandom_range(40) - 20, $urandom_range(40) - 20);
            end
            pending_quats.push_back(q);
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_angles.push_back(predict_angles(t_quat'(s_axis_tdata)));
                send_gap = $urandom_range(6);
                if ($urandom_range(3) == 0) send_gap = 0;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // Hold the current request.
            end else if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_quats.size() > 0) begin
                s_axis_tdata <= pending_quats.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
                stim_done = 1'b1;
            end
        end
    end

    // Monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_euler got;
        t_euler want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_euler'(m_axis_tdata[46:0]);
                received++;
                if (expected_angles.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %h", m_axis_tdata);
                end else begin
                    want = expected_angles.pop_front();
                    if (got !== want || m_axis_tdata[47] !== 1'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch roll %0d/%0d pitch %0d/%0d yaw %0d/%0d",
                                     want.roll_angle, got.roll_angle, want.pitch_angle,
                                     got.pitch_angle, want.yaw_angle, got.yaw_angle);
                    end
                end
                recv_gap = $urandom_range(6);
                if ($urandom_range(3) == 0) recv_gap = 0;
            end
            if (received == hold_trigger && hold_off == 0) begin
                hold_off = 200;
                hold_trigger = -1;
            end
            if (hold_off > 0) begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog and end of run.
    initial begin
        int tail;
        tail = 0;
        @(posedge i_rst_n);
        while (tail < 2 * Latency) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("Regression FAIL");
                $finish;
            end
            if (stim_done && expected_angles.size() == 0) tail++;
        end
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[quaternion_to_euler.f]
hdl/q2e_pkg.sv
hdl/quaternion_to_euler.sv
dv/tb_quaternion_to_euler.sv
